// File: hdl/qmtl_pkg.sv
// Package for the quad motor trim learner: fixed-point constants, codes and
// the payload and state structures shared by every file of the block.
// Depends on nothing.
`timescale 1ns / 1ps

package qmtl_pkg;

  localparam int unsigned MOTOR_COUNT = 4;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned Q_W         = FRAC_BITS + 1;
  localparam int unsigned CMD_W       = 16;
  localparam int unsigned HOLD_W      = 7;
  localparam int unsigned ACC_W       = 2 * Q_W;
  localparam int unsigned AVG_W       = ACC_W - FRAC_BITS;

  localparam longint unsigned ONE_L   = 64'd1 << FRAC_BITS;
  localparam longint unsigned W_OLD_L = (ONE_L * 95 + 50) / 100;

  localparam logic [Q_W-1:0] ONE       = Q_W'(ONE_L);
  localparam logic [Q_W-1:0] HALF      = Q_W'(ONE_L >> 1);
  localparam logic [Q_W-1:0] W_OLD     = Q_W'(W_OLD_L);
  localparam logic [Q_W-1:0] W_NEW     = Q_W'(ONE_L - W_OLD_L);
  localparam logic [Q_W-1:0] TRIM_MIN  = Q_W'((ONE_L * 85 + 50) / 100);
  localparam logic [Q_W-1:0] THR_LIMIT = Q_W'((ONE_L * 99) / 100);

  localparam logic [HOLD_W-1:0] HOLD_START = HOLD_W'(49);
  localparam logic [HOLD_W-1:0] HOLD_END   = HOLD_W'(99);

  typedef logic [Q_W-1:0]                      q_t;
  typedef logic signed [CMD_W-1:0]             cmd_t;
  typedef logic [MOTOR_COUNT-1:0][Q_W-1:0]     trim_vec_t;

  typedef enum logic [0:0] {
    CFG_TRIM_ENABLE    = 1'b0,
    CFG_LEARN_ASSIGNED = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_NEVER    = 2'd0,
    STATUS_ACTIVE   = 2'd1,
    STATUS_RELEASED = 2'd2
  } status_e;

  typedef struct packed {
    logic trim_enable;
    logic learn_mode_assigned;
  } cfg_t;

  typedef struct packed {
    logic armed;
    logic learn_active;
    q_t   throttle;
    cmd_t roll_cmd;
    cmd_t pitch_cmd;
    cmd_t yaw_cmd;
    q_t   motor_out_0;
    q_t   motor_out_1;
    q_t   motor_out_2;
    q_t   motor_out_3;
  } in_item_t;

  typedef struct packed {
    q_t      trim_0;
    q_t      trim_1;
    q_t      trim_2;
    q_t      trim_3;
    logic    trim_updated;
    status_e trim_status;
  } out_item_t;

  typedef struct packed {
    logic [HOLD_W-1:0] hold_count;
    status_e           phase;
    trim_vec_t         trim;
  } learn_state_t;

endpackage

// File: hdl/qmtl_in_if.sv
// Valid/ready channel carrying one control tick into the trim learner.
// Depends on qmtl_pkg.
`timescale 1ns / 1ps

interface qmtl_in_if;
  logic               valid;
  logic               ready;
  qmtl_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/qmtl_out_if.sv
// Valid/ready channel carrying one trim result out of the trim learner.
// Depends on qmtl_pkg.
`timescale 1ns / 1ps

interface qmtl_out_if;
  logic                valid;
  logic                ready;
  qmtl_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/qmtl_update.sv
// Next-state and result logic for one tick: hold test, counter, weighted
// trim average with clamp, and levelling so the tallest trim is full scale.
// Depends on qmtl_pkg.
`timescale 1ns / 1ps

module qmtl_update (
  input  qmtl_pkg::cfg_t         cfg_i,
  input  qmtl_pkg::learn_state_t state_i,
  input  qmtl_pkg::in_item_t     item_i,
  output qmtl_pkg::learn_state_t state_o,
  output qmtl_pkg::out_item_t    result_o
);
  import qmtl_pkg::*;

  q_t                motor    [MOTOR_COUNT];
  logic [ACC_W-1:0]  acc      [MOTOR_COUNT];
  logic [AVG_W-1:0]  avg      [MOTOR_COUNT];
  q_t                clamped  [MOTOR_COUNT];
  q_t                tallest;
  q_t                raise;
  logic              gate;
  logic              centred;
  logic              hold;
  logic [HOLD_W-1:0] cnt_next;
  logic              do_trim;

  assign motor[0] = item_i.motor_out_0;
  assign motor[1] = item_i.motor_out_1;
  assign motor[2] = item_i.motor_out_2;
  assign motor[3] = item_i.motor_out_3;

  // Weighted average rounded to nearest, then held within the trim range.
  always_comb begin
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      acc[i] = ACC_W'(state_i.trim[i]) * ACC_W'(W_OLD)
             + ACC_W'(motor[i]) * ACC_W'(W_NEW) + ACC_W'(HALF);
      avg[i] = acc[i][ACC_W-1:FRAC_BITS];
      if (avg[i] < AVG_W'(TRIM_MIN)) begin
        clamped[i] = TRIM_MIN;
      end else if (avg[i] > AVG_W'(ONE)) begin
        clamped[i] = ONE;
      end else begin
        clamped[i] = avg[i][Q_W-1:0];
      end
    end
  end

  always_comb begin
    tallest = clamped[0];
    for (int i = 1; i < MOTOR_COUNT; i++) begin
      if (clamped[i] > tallest) begin
        tallest = clamped[i];
      end
    end
    raise = ONE - tallest;
  end

  assign gate    = cfg_i.learn_mode_assigned & cfg_i.trim_enable & item_i.armed;
  assign centred = (item_i.roll_cmd == '0) && (item_i.pitch_cmd == '0) &&
                   (item_i.yaw_cmd == '0);
  assign hold    = item_i.learn_active && (item_i.throttle > THR_LIMIT) && centred;

  assign cnt_next = hold ? state_i.hold_count + HOLD_W'(1) : '0;
  assign do_trim  = gate && (cnt_next > HOLD_START);

  always_comb begin
    state_o = state_i;
    if (gate) begin
      state_o.hold_count = cnt_next;
      if (!hold && state_i.phase == STATUS_ACTIVE) begin
        state_o.phase = STATUS_RELEASED;
      end
    end
    if (do_trim) begin
      state_o.phase = STATUS_ACTIVE;
      if (cnt_next >= HOLD_END) begin
        state_o.hold_count = '0;
      end
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        // No trim exceeds the tallest, so the sum stays within full scale.
        state_o.trim[i] = clamped[i] + raise;
      end
    end
  end

  always_comb begin
    result_o.trim_0       = state_o.trim[0];
    result_o.trim_1       = state_o.trim[1];
    result_o.trim_2       = state_o.trim[2];
    result_o.trim_3       = state_o.trim[3];
    result_o.trim_updated = do_trim;
    result_o.trim_status  = state_o.phase;
  end

endmodule

// File: hdl/quad_motor_trim_learner.sv
// Quad motor trim learner: one result request for every tick request taken.
// A tick is accepted in every cycle while the pipeline moves; it is held in
// an input register, evaluated combinationally against the learned state
// and placed in a result register, from which the result is presented; a
// stalled result holds the input register behind it. The combinational
// update of the counter, status and four trims from the registered tick
// sets the rate of one tick per cycle while the result is not stalled. The
// configuration bits should be written only while no tick is in flight.
// Depends on qmtl_pkg, qmtl_in_if, qmtl_out_if and qmtl_update.
`timescale 1ns / 1ps

module quad_motor_trim_learner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  qmtl_pkg::cfg_idx_e cfg_idx_i,
  input  logic               cfg_data_i,
  qmtl_in_if.sink            in_i,
  qmtl_out_if.source         out_o
);
  import qmtl_pkg::*;

  cfg_t         cfg_q;
  logic         in_valid_q;
  in_item_t     in_item_q;
  logic         out_valid_q;
  out_item_t    out_item_q;
  learn_state_t state_q;
  learn_state_t state_d;
  out_item_t    result_d;
  logic         advance;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRIM_ENABLE:    cfg_q.trim_enable         <= cfg_data_i;
        CFG_LEARN_ASSIGNED: cfg_q.learn_mode_assigned <= cfg_data_i;
        default: ;
      endcase
    end
  end

  qmtl_update u_update (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.hold_count <= '0;
      state_q.phase      <= STATUS_NEVER;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        state_q.trim[i] <= ONE;
      end
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.payload;
    end
    if (advance) begin
      out_item_q <= result_d;
    end
  end

  hold_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hold_count <= HOLD_END)
    else $error("hold counter ran past its end value");

  for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_trim_chk
    trim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q.trim[g] >= TRIM_MIN) && (state_q.trim[g] <= ONE))
      else $error("stored trim left its permitted range");
  end

  update_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.trim_updated |->
      (out_item_q.trim_status == STATUS_ACTIVE) &&
      ((out_item_q.trim_0 == ONE) || (out_item_q.trim_1 == ONE) ||
       (out_item_q.trim_2 == ONE) || (out_item_q.trim_3 == ONE)))
    else $error("trim update did not level to full scale or set status");

  no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_item_q))
    else $error("pending result was lost or changed while stalled");

endmodule
